/* rtl/swrl_pkg.sv */
// shared types, constants and field layout of the sliding window rate limiter
package swrl_pkg;

  // field widths
  localparam int unsigned FLOW_SLOT_W = 8;
  localparam int unsigned PLAN_CODE_W = 3;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned RETRY_W     = 12;
  localparam int unsigned LIMIT_W     = 8;
  localparam int unsigned WINDOW_W    = 12;

  // stream word layout
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_FREE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_PRO      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ELITE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_FALLBACK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 3'd4;

  // register reset values
  localparam logic [LIMIT_W-1:0]  LIMIT_FREE_RST     = 8'd3;
  localparam logic [LIMIT_W-1:0]  LIMIT_PRO_RST      = 8'd5;
  localparam logic [LIMIT_W-1:0]  LIMIT_ELITE_RST    = 8'd100;
  localparam logic [LIMIT_W-1:0]  LIMIT_FALLBACK_RST = 8'd2;
  localparam logic [WINDOW_W-1:0] WINDOW_LENGTH_RST  = 12'd60;

  // plan codes
  localparam logic [PLAN_CODE_W-1:0] PLAN_FREE  = 3'd0;
  localparam logic [PLAN_CODE_W-1:0] PLAN_PRO   = 3'd1;
  localparam logic [PLAN_CODE_W-1:0] PLAN_ELITE = 3'd2;

  localparam logic [RETRY_W-1:0] RETRY_MAX = 12'd4095;

  // default sizes
  localparam int unsigned NUM_SLOTS_DEF = 256;
  localparam int unsigned LOG_DEPTH_DEF = 128;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META,
    ST_CHECK
  } swrl_state_e;

endpackage

/* rtl/swrl_ram.sv */
// generic single write port ram with registered read
module swrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sliding_window_rate_limiter.sv */
// top level of the sliding window log rate limiter
//
// usage
// - input stream: one word per request, fields flow slot, plan code and the
//   current time in seconds; one output word per request with the decision
//   and, when denied, the seconds to wait before a retry
// - per-slot head and count live in a metadata ram, logged accept times in a
//   stamp ram of NUM_SLOTS x LOG_DEPTH entries; both are read, updated and
//   written back one request at a time
// - flow: each accepted request passes ST_META and then ST_CHECK, which repeats
//   for every expired log entry dropped; the stamp ram read per drop sets the pace
// - a new request is taken only after the previous one has left ST_CHECK; each
//   logged entry is dropped at most once
// - reset: the limits and window go to their defaults and a clearing pass of
//   all NUM_SLOTS entries zeroes the metadata ram; tready stays low until it ends;
//   configuration writes are taken at any time
// - stall: a finished result waits in the output register; the next request
//   is accepted and worked on, and only its write-back waits for the slot
module sliding_window_rate_limiter
  import swrl_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int unsigned LOG_DEPTH = LOG_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // flow_slot[7:0], plan_code[10:8], time_now[42:11]
  // decision stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,  // allowed[0], retry seconds[12:1]
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned HEAD_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(LOG_DEPTH + 1);
  localparam int unsigned META_W  = COUNT_W + HEAD_W;
  localparam int unsigned STAMP_DEPTH = NUM_SLOTS * LOG_DEPTH;
  localparam int unsigned ADDR_W  = (STAMP_DEPTH > 1) ? $clog2(STAMP_DEPTH) : 1;
  localparam int unsigned LIM_W   = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;
  localparam int unsigned SUM_W   = COUNT_W + 1;
  localparam int unsigned SLOT_TBL_N = 1 << FLOW_SLOT_W;

  // input word fields
  logic [FLOW_SLOT_W-1:0] in_slot;
  logic [PLAN_CODE_W-1:0] in_plan;
  logic [TIME_W-1:0]      in_time;

  assign in_slot = s_axis_tdata[FLOW_SLOT_W-1:0];
  assign in_plan = s_axis_tdata[FLOW_SLOT_W +: PLAN_CODE_W];
  assign in_time = s_axis_tdata[FLOW_SLOT_W+PLAN_CODE_W +: TIME_W];

  // configuration registers
  logic [LIMIT_W-1:0]  lim_free_q, lim_pro_q, lim_elite_q, lim_fallback_q;
  logic [WINDOW_W-1:0] window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_free_q     <= LIMIT_FREE_RST;
      lim_pro_q      <= LIMIT_PRO_RST;
      lim_elite_q    <= LIMIT_ELITE_RST;
      lim_fallback_q <= LIMIT_FALLBACK_RST;
      window_q       <= WINDOW_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LIMIT_FREE:     lim_free_q     <= cfg_wdata_i[LIMIT_W-1:0];
        REG_LIMIT_PRO:      lim_pro_q      <= cfg_wdata_i[LIMIT_W-1:0];
        REG_LIMIT_ELITE:    lim_elite_q    <= cfg_wdata_i[LIMIT_W-1:0];
        REG_LIMIT_FALLBACK: lim_fallback_q <= cfg_wdata_i[LIMIT_W-1:0];
        REG_WINDOW_LENGTH:  window_q       <= cfg_wdata_i[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // slot reduction table: flow_slot modulo NUM_SLOTS, built at elaboration
  logic [SLOT_W-1:0] slot_tbl [SLOT_TBL_N];

  for (genvar g = 0; g < SLOT_TBL_N; g++) begin : g_slot_tbl
    assign slot_tbl[g] = SLOT_W'(g % NUM_SLOTS);
  end

  logic [SLOT_W-1:0] slot_sel;
  assign slot_sel = slot_tbl[in_slot];

  // plan limit, capped at the log depth
  logic [LIMIT_W-1:0] plan_lim;
  logic [LIM_W-1:0]   plan_lim_cap;

  always_comb begin
    case (in_plan)
      PLAN_FREE:  plan_lim = lim_free_q;
      PLAN_PRO:   plan_lim = lim_pro_q;
      PLAN_ELITE: plan_lim = lim_elite_q;
      default:    plan_lim = lim_fallback_q;
    endcase
    if (LIM_W'(plan_lim) > LIM_W'(LOG_DEPTH)) begin
      plan_lim_cap = LIM_W'(LOG_DEPTH);
    end else begin
      plan_lim_cap = LIM_W'(plan_lim);
    end
  end

  // request context
  swrl_state_e        state_q, state_d;
  logic [SLOT_W-1:0]  clr_q, clr_d;
  logic [SLOT_W-1:0]  slot_q;
  logic [ADDR_W-1:0]  base_q;
  logic [LIM_W-1:0]   lim_q;
  logic [TIME_W-1:0]  now_q;
  logic [HEAD_W-1:0]  head_q, head_d;
  logic [COUNT_W-1:0] count_q, count_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic               out_allowed_q, out_allowed_d;
  logic [RETRY_W-1:0] out_retry_q, out_retry_d;
  logic               out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  // memory ports
  logic              meta_we, meta_re;
  logic [SLOT_W-1:0] meta_waddr, meta_raddr;
  logic [META_W-1:0] meta_wdata, meta_rdata;
  logic              stamp_we, stamp_re;
  logic [ADDR_W-1:0] stamp_waddr, stamp_raddr;
  logic [TIME_W-1:0] stamp_rdata;

  swrl_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_SLOTS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (meta_re),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  swrl_ram #(
    .WIDTH (TIME_W),
    .DEPTH (STAMP_DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (stamp_waddr),
    .wdata_i (now_q),
    .re_i    (stamp_re),
    .raddr_i (stamp_raddr),
    .rdata_o (stamp_rdata)
  );

  // metadata word: count above head
  logic [HEAD_W-1:0]  meta_head;
  logic [COUNT_W-1:0] meta_count;

  assign meta_head  = meta_rdata[HEAD_W-1:0];
  assign meta_count = meta_rdata[HEAD_W +: COUNT_W];

  // ring arithmetic
  logic [HEAD_W-1:0] head_inc;
  logic [SUM_W-1:0]  tail_sum;
  logic [HEAD_W-1:0] tail;

  assign head_inc = (head_q == HEAD_W'(LOG_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
  assign tail     = (tail_sum >= SUM_W'(LOG_DEPTH)) ?
                    HEAD_W'(tail_sum - SUM_W'(LOG_DEPTH)) : HEAD_W'(tail_sum);

  // expiry of the oldest entry and retry wait
  logic [TIME_W:0] oldest, expiry, wait_raw;
  logic            expired;
  logic [RETRY_W-1:0] wait_sat;

  always_comb begin
    oldest   = (count_q != '0) ? {1'b0, stamp_rdata} : {1'b0, now_q};
    expiry   = oldest + (TIME_W + 1)'(window_q);
    expired  = expiry <= {1'b0, now_q};
    wait_raw = expiry - {1'b0, now_q};
    if (expired) begin
      wait_sat = '0;
    end else if (wait_raw > (TIME_W + 1)'(RETRY_MAX)) begin
      wait_sat = RETRY_MAX;
    end else begin
      wait_sat = wait_raw[RETRY_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    head_d        = head_q;
    count_d       = count_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_allowed_d = out_allowed_q;
    out_retry_d   = out_retry_q;
    s_axis_tready = 1'b0;
    meta_re       = 1'b0;
    meta_raddr    = slot_sel;
    meta_we       = 1'b0;
    meta_waddr    = slot_q;
    stamp_re      = 1'b0;
    stamp_raddr   = base_q + ADDR_W'(head_q);
    stamp_we      = 1'b0;
    stamp_waddr   = base_q + ADDR_W'(tail);

    unique case (state_q)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        if (clr_q == SLOT_W'(NUM_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          meta_re = 1'b1;
          state_d = ST_META;
        end
      end
      ST_META: begin
        head_d      = meta_head;
        count_d     = meta_count;
        stamp_re    = 1'b1;
        stamp_raddr = base_q + ADDR_W'(meta_head);
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        if (count_q != '0 && expired) begin
          // drop the oldest entry and fetch the next one
          head_d      = head_inc;
          count_d     = count_q - 1'b1;
          stamp_re    = 1'b1;
          stamp_raddr = base_q + ADDR_W'(head_inc);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          meta_we     = 1'b1;
          if (LIM_W'(count_q) >= lim_q) begin
            out_allowed_d = 1'b0;
            out_retry_d   = wait_sat;
          end else begin
            stamp_we      = 1'b1;
            count_d       = count_q + 1'b1;
            out_allowed_d = 1'b1;
            out_retry_d   = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign meta_wdata = (state_q == ST_CLEAR) ? '0 : {count_d, head_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    head_q        <= head_d;
    count_q       <= count_d;
    out_allowed_q <= out_allowed_d;
    out_retry_q   <= out_retry_d;
    if (s_axis_tvalid && s_axis_tready) begin
      slot_q <= slot_sel;
      base_q <= ADDR_W'(slot_sel) * ADDR_W'(LOG_DEPTH);
      lim_q  <= plan_lim_cap;
      now_q  <= in_time;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W - RETRY_W - 1)'(0), out_retry_q, out_allowed_q};

endmodule

/* tb/sv/tb_sliding_window_rate_limiter.sv */
// testbench of the sliding window rate limiter: directed rows, then random traffic checked by a log model
`timescale 1ns / 100ps

module tb_sliding_window_rate_limiter;
  import swrl_pkg::*;

  localparam int unsigned NUM_SLOTS   = NUM_SLOTS_DEF;
  localparam int unsigned LOG_DEPTH   = LOG_DEPTH_DEF;
  localparam int unsigned SETTLE      = 16;       // cycles after the last word before a reload
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned RAND_PHASES = 14;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam int unsigned MAX_REPORTS = 10;

  // plan codes beyond the three named in the package
  localparam logic [PLAN_CODE_W-1:0] PLAN_DISCOVER = 3'd3;
  localparam logic [PLAN_CODE_W-1:0] PLAN_UNKNOWN  = 3'd4;
  localparam logic [PLAN_CODE_W-1:0] PLAN_CODE_TOP = 3'd7;

  // request word, flow_slot in the lowest bits
  typedef struct packed {
    logic [TIME_W-1:0]      time_now;
    logic [PLAN_CODE_W-1:0] plan_code;
    logic [FLOW_SLOT_W-1:0] flow_slot;
  } request_t;

  // decision word, allowed in bit 0
  typedef struct packed {
    logic [RETRY_W-1:0] retry_wait;
    logic               allowed;
  } decision_t;

  typedef struct {
    request_t  req;
    bit        fixed;  // decision typed in by hand
    decision_t want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  sliding_window_rate_limiter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // shadow of the limits, the window and the per-slot stamp logs
  logic [LIMIT_W-1:0]  lim_free;
  logic [LIMIT_W-1:0]  lim_pro;
  logic [LIMIT_W-1:0]  lim_elite;
  logic [LIMIT_W-1:0]  lim_fallback;
  logic [WINDOW_W-1:0] window_len;
  logic [TIME_W-1:0]   stamp_mem [NUM_SLOTS][LOG_DEPTH];
  int unsigned         head_mem  [NUM_SLOTS];
  int unsigned         fill_mem  [NUM_SLOTS];

  decision_t   pending_decisions[$];
  row_t        directed_rows[$];
  bit          snd_quiet = 1'b0;
  bit          rcv_quiet = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned n_requests = 0;
  int unsigned n_allowed = 0;
  int unsigned n_denied = 0;
  int unsigned n_ceiling = 0;
  int unsigned n_loads = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // decision of one request, updating the slot log as the block does
  function automatic decision_t decide_request(request_t rq);
    decision_t       d;
    int unsigned     slot;
    int unsigned     head;
    int unsigned     fill;
    int unsigned     lim;
    longint unsigned now;
    longint unsigned win;
    longint unsigned oldest;
    longint unsigned expiry;
    longint unsigned wait_s;
    slot = 32'(rq.flow_slot) % NUM_SLOTS;
    now  = 64'(rq.time_now);
    win  = 64'(window_len);
    case (rq.plan_code)
      PLAN_FREE:  lim = 32'(lim_free);
      PLAN_PRO:   lim = 32'(lim_pro);
      PLAN_ELITE: lim = 32'(lim_elite);
      default:    lim = 32'(lim_fallback);  // discover and every unknown code
    endcase
    // a limit above the log depth means a full log denies
    if (lim > LOG_DEPTH) lim = LOG_DEPTH;
    head = head_mem[slot];
    fill = fill_mem[slot];
    // expired stamps leave from the head, stamp + window <= now in 33+ bits
    while (fill > 0) begin
      oldest = 64'(stamp_mem[slot][head]);
      if (oldest + win > now) break;
      head = (head + 1) % LOG_DEPTH;
      fill--;
    end
    if (fill >= lim) begin
      // an empty log counts its oldest stamp as now
      oldest = (fill > 0) ? 64'(stamp_mem[slot][head]) : now;
      expiry = oldest + win;
      wait_s = (expiry > now) ? expiry - now : 0;
      if (wait_s > 64'(RETRY_MAX)) wait_s = 64'(RETRY_MAX);
      d.allowed    = 1'b0;
      d.retry_wait = wait_s[RETRY_W-1:0];
    end else begin
      stamp_mem[slot][(head + fill) % LOG_DEPTH] = rq.time_now;
      fill++;
      d.allowed    = 1'b1;
      d.retry_wait = '0;
    end
    head_mem[slot] = head;
    fill_mem[slot] = fill;
    return d;
  endfunction

  // one request word; valid stays up when the next word follows at once
  task automatic push_request(request_t rq, bit fixed, decision_t want);
    int unsigned gap;
    decision_t   model;
    gap = snd_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - $bits(request_t)){1'b0}}, rq};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    model = decide_request(rq);
    if (fixed) model = want;
    pending_decisions.insert(pending_decisions.size(), model);
    n_requests++;
    if (model.allowed) n_allowed++;
    else n_denied++;
    if (model.retry_wait == RETRY_MAX) n_ceiling++;
  endtask

  // stop sending and let every outstanding decision come back
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // writes all five registers, block must be idle
  task automatic load_limits(logic [LIMIT_W-1:0] f, logic [LIMIT_W-1:0] p,
                             logic [LIMIT_W-1:0] e, logic [LIMIT_W-1:0] fb,
                             logic [WINDOW_W-1:0] w);
    cfg_write(REG_LIMIT_FREE, CFG_DATA_W'(f));
    cfg_write(REG_LIMIT_PRO, CFG_DATA_W'(p));
    cfg_write(REG_LIMIT_ELITE, CFG_DATA_W'(e));
    cfg_write(REG_LIMIT_FALLBACK, CFG_DATA_W'(fb));
    cfg_write(REG_WINDOW_LENGTH, CFG_DATA_W'(w));
    cfg_we_i     <= 1'b0;
    lim_free     = f;
    lim_pro      = p;
    lim_elite    = e;
    lim_fallback = fb;
    window_len   = w;
    n_loads++;
    @(posedge clk_i);
  endtask

  task automatic add_row(logic [FLOW_SLOT_W-1:0] slot, logic [PLAN_CODE_W-1:0] plan,
                         logic [TIME_W-1:0] t, bit fixed = 1'b0, logic ok = 1'b0,
                         logic [RETRY_W-1:0] retry = '0);
    row_t r;
    r.req.flow_slot    = slot;
    r.req.plan_code    = plan;
    r.req.time_now     = t;
    r.fixed            = fixed;
    r.want.allowed     = ok;
    r.want.retry_wait  = retry;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  task automatic run_rows();
    foreach (directed_rows[i])
      push_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);
    directed_rows.delete();
    settle_block();
  endtask

  // decision sink with random stalls
  initial begin : drain_decisions
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rcv_quiet ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
    end
  end

  // compare each decision word with the oldest expectation
  always @(posedge clk_i) begin : check_decisions
    decision_t got;
    decision_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(decision_t)-1:0];
      if (pending_decisions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("tb: unexpected word allowed=%0d retry=%0d", got.allowed, got.retry_wait);
      end else begin
        want = pending_decisions[0];
        pending_decisions.delete(0);
        if (got.allowed !== want.allowed || got.retry_wait !== want.retry_wait) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("tb: mismatch expected allowed=%0d retry=%0d, got allowed=%0d retry=%0d",
                     want.allowed, want.retry_wait, got.allowed, got.retry_wait);
        end
      end
    end
  end

  initial begin : stimulus
    request_t            rq;
    logic [FLOW_SLOT_W-1:0] hot_slots [4];
    logic [FLOW_SLOT_W-1:0] flood_slot;
    logic [TIME_W-1:0]   clock_s;
    logic [WINDOW_W-1:0] win;
    logic [LIMIT_W-1:0]  lims [4];

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_wdata_i   <= '0;
    lim_free      = LIMIT_FREE_RST;
    lim_pro       = LIMIT_PRO_RST;
    lim_elite     = LIMIT_ELITE_RST;
    lim_fallback  = LIMIT_FALLBACK_RST;
    window_len    = WINDOW_LENGTH_RST;
    foreach (head_mem[i]) begin
      head_mem[i] = 0;
      fill_mem[i] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset limits: free 3, fallback 2, window 60
    add_row(8'd0, PLAN_FREE, 32'd100, 1'b1, 1'b1, 12'd0);
    add_row(8'd0, PLAN_FREE, 32'd100, 1'b1, 1'b1, 12'd0);
    add_row(8'd0, PLAN_FREE, 32'd110, 1'b1, 1'b1, 12'd0);
    add_row(8'd0, PLAN_FREE, 32'd120, 1'b1, 1'b0, 12'd40);   // full, oldest 100 expires at 160
    add_row(8'd0, PLAN_FREE, 32'd160);                       // both 100 stamps drop
    add_row(8'd0, PLAN_FREE, 32'd50);                        // clock steps backwards
    add_row(8'd0, PLAN_FREE, 32'd50);
    add_row(8'd255, PLAN_UNKNOWN, 32'd200, 1'b1, 1'b1, 12'd0);
    add_row(8'd255, PLAN_CODE_TOP, 32'd200, 1'b1, 1'b1, 12'd0);
    add_row(8'd255, PLAN_DISCOVER, 32'd201, 1'b1, 1'b0, 12'd59);
    add_row(8'd1, PLAN_ELITE, 32'hFFFF_FFFF, 1'b1, 1'b1, 12'd0);
    add_row(8'd1, PLAN_CODE_TOP, 32'hFFFF_FFFF);
    add_row(8'd1, PLAN_UNKNOWN, 32'hFFFF_FFFF, 1'b1, 1'b0, 12'd60);  // expiry carries past 32 bits
    add_row(8'd128, PLAN_PRO, 32'd0, 1'b1, 1'b1, 12'd0);
    add_row(8'd1, PLAN_DISCOVER, 32'd5, 1'b1, 1'b0, RETRY_MAX);      // far backwards, saturates
    run_rows();

    // zero window, zero free limit, pro above the log depth
    load_limits(8'd0, 8'd255, 8'd128, 8'd128, 12'd0);
    add_row(8'd3, PLAN_FREE, 32'd500, 1'b1, 1'b0, 12'd0);   // empty log, wait is the window
    add_row(8'd4, PLAN_PRO, 32'd500, 1'b1, 1'b1, 12'd0);
    add_row(8'd4, PLAN_PRO, 32'd500, 1'b1, 1'b1, 12'd0);    // previous stamp expired at once
    add_row(8'd4, PLAN_DISCOVER, 32'd400);
    run_rows();

    // widest window
    load_limits(8'd0, 8'd1, 8'd0, 8'd0, 12'd4095);
    add_row(8'd5, PLAN_FREE, 32'd10, 1'b1, 1'b0, RETRY_MAX);
    add_row(8'd5, PLAN_ELITE, 32'd10, 1'b1, 1'b0, RETRY_MAX);
    add_row(8'd6, PLAN_PRO, 32'd1000, 1'b1, 1'b1, 12'd0);
    add_row(8'd6, PLAN_PRO, 32'd1000, 1'b1, 1'b0, RETRY_MAX);
    run_rows();

    load_limits(8'd128, LIMIT_PRO_RST, LIMIT_ELITE_RST, LIMIT_FALLBACK_RST, 12'd3600);
    add_row(8'd7, PLAN_FREE, 32'd7, 1'b1, 1'b1, 12'd0);
    add_row(8'd7, PLAN_FREE, 32'd3607);
    run_rows();

    // flood one slot past the log depth, with the limit capped; whole log drops at once
    load_limits(8'd2, 8'd255, 8'd1, 8'd0, 12'd4);
    flood_slot = 8'($urandom_range(0, 255));
    clock_s    = $urandom();
    snd_quiet  = 1'b1;
    for (int b = 0; b < 3; b++) begin
      for (int n = 0; n < ((b == 2) ? 40 : 130); n++) begin
        rq.flow_slot = flood_slot;
        rq.plan_code = PLAN_PRO;
        rq.time_now  = clock_s;
        push_request(rq, 1'b0, '0);
        if (n == 64) snd_quiet = 1'b0;
      end
      clock_s = clock_s + ((b == 0) ? 4 : 2);
    end

    // random phases: fresh limits each time, traffic mostly on a few hot slots
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle_block();
      foreach (lims[k]) begin
        case ($urandom_range(0, 9))
          0:       lims[k] = '0;
          1:       lims[k] = 8'd128;
          2:       lims[k] = 8'($urandom_range(129, 255));
          default: lims[k] = 8'($urandom_range(1, 8));
        endcase
      end
      case ($urandom_range(0, 11))
        0:       win = '0;
        1:       win = 12'd3600;
        2:       win = 12'd4095;
        3, 4:    win = 12'($urandom_range(21, 4095));
        default: win = 12'($urandom_range(1, 20));
      endcase
      load_limits(lims[0], lims[1], lims[2], lims[3], win);
      snd_quiet = ($urandom_range(0, 3) == 0);
      rcv_quiet = ($urandom_range(0, 3) == 0);
      foreach (hot_slots[k]) hot_slots[k] = 8'($urandom_range(0, 255));
      // some phases run near the top of the time range
      clock_s = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000)
                                            : $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rq.flow_slot = ($urandom_range(0, 4) != 0) ? hot_slots[$urandom_range(0, 3)]
                                                   : 8'($urandom_range(0, 255));
        rq.plan_code = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 29))
          0:       clock_s = clock_s - $urandom_range(1, 100);  // clock steps backwards
          1, 2, 3: clock_s = clock_s + $urandom_range(0, win);
          default: clock_s = clock_s + $urandom_range(0, 2);
        endcase
        rq.time_now = clock_s;
        push_request(rq, 1'b0, '0);
        // stretches with and without idling on both sides
        if (n % 37 == 36) snd_quiet = !snd_quiet;
        if (n % 29 == 28) rcv_quiet = !rcv_quiet;
      end
    end

    settle_block();
    $display("tb: %0d requests, %0d allowed, %0d denied, %0d waits at the ceiling",
             n_requests, n_allowed, n_denied, n_ceiling);
    $display("tb: %0d register loads, windows 0 to 4095, limits 0 to 255, all plan codes",
             n_loads);
    if (mismatch_count == 0 && pending_decisions.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
